>>> rtl/core/text_literal_escape_decoder_macros.svh
// assertion macros for the text literal escape decoder
`ifndef TEXT_LITERAL_ESCAPE_DECODER_MACROS_SVH
`define TEXT_LITERAL_ESCAPE_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TLED_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TLED_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tled_pkg.sv
// shared types, codes and character constants of the text literal escape decoder
package tled_pkg;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_BODY = 3'd1,
		PH_ESC  = 3'd2,
		PH_HEX  = 3'd3,
		PH_OCT  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		K_BYTE = 2'd0,
		K_END  = 2'd1,
		K_ERR  = 2'd2
	} kind_t;

	localparam logic [2:0] E_NONE    = 3'd0;
	localparam logic [2:0] E_EOL     = 3'd1;
	localparam logic [2:0] E_NUL     = 3'd2;
	localparam logic [2:0] E_BAD_HEX = 3'd3;
	localparam logic [2:0] E_BAD_OCT = 3'd4;
	localparam logic [2:0] E_UNI_RNG = 3'd5;
	localparam logic [2:0] E_OCT_RNG = 3'd6;
	localparam logic [2:0] E_UNKNOWN = 3'd7;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_DQ  = 8'h22;
	localparam logic [7:0] CH_SQ  = 8'h27;
	localparam logic [7:0] CH_D0  = 8'h30;
	localparam logic [7:0] CH_D7  = 8'h37;
	localparam logic [7:0] CH_D9  = 8'h39;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_UU  = 8'h55;
	localparam logic [7:0] CH_UX  = 8'h58;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF_ = 8'h66;
	localparam logic [7:0] CH_LN  = 8'h6E;
	localparam logic [7:0] CH_LR  = 8'h72;
	localparam logic [7:0] CH_LT  = 8'h74;
	localparam logic [7:0] CH_LX  = 8'h78;

	localparam logic [7:0]  BYTE_MAX = 8'hFF;
	localparam logic [15:0] LEN_MAX  = 16'hFFFF;
	localparam logic [2:0]  HEX_DIGITS = 3'd2;
	localparam logic [2:0]  UNI_DIGITS = 3'd6;
	localparam logic [2:0]  OCT_MORE   = 3'd2;

	typedef struct packed {
		logic [7:0] ch;
		logic       start_req;
	} word_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  digits_left;
		logic [23:0] escape_value;
		logic        unicode_escape;
		logic [15:0] decoded_count;
	} state_t;

	typedef struct packed {
		logic        has;
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [2:0]  error_code;
		logic [15:0] text_length;
	} result_t;

	// bit 4 flags a valid hex digit, low nibble is its value
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= CH_D0 && c <= CH_D9) begin
			r = {1'b1, 4'(c - CH_D0)};
		end else if (c >= CH_UA && c <= CH_UF) begin
			r = {1'b1, 4'(c - CH_UA + 8'd10)};
		end else if (c >= CH_LA && c <= CH_LF_) begin
			r = {1'b1, 4'(c - CH_LA + 8'd10)};
		end
		return r;
	endfunction

endpackage

>>> rtl/core/tled_in_stage.sv
// input register stage: captures one word and holds it while the result side is blocked
module tled_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	input  logic [7:0]      ch,
	input  logic            start_req,
	input  logic            blocked,
	output logic            stall,
	output logic            process,
	output tled_pkg::word_t word_s1
);

	logic v_s1;
	logic load;

	assign stall   = v_s1 & blocked;
	assign load    = valid & ~stall;
	assign process = v_s1 & ~blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= load | (v_s1 & blocked);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_s1.ch        <= ch;
			word_s1.start_req <= start_req;
		end
	end

endmodule

>>> rtl/core/tled_step.sv
// per-word decode: next state and the optional result for one word
module tled_step (
	input  tled_pkg::word_t   word,
	input  tled_pkg::state_t  st_q,
	output tled_pkg::state_t  st_d,
	output tled_pkg::result_t res
);

	tled_pkg::state_t st;
	logic [7:0]  c;
	logic [4:0]  hx;
	logic [23:0] ev_hex;
	logic [23:0] ev_oct;
	logic [2:0]  dl_dec;
	logic        put;
	logic [7:0]  put_val;
	logic        fail;
	logic [2:0]  fail_code;
	logic        lit_end;

	assign c      = word.ch;
	assign hx     = tled_pkg::hex_decode(c);
	assign dl_dec = st.digits_left - 3'd1;
	assign ev_hex = {st.escape_value[19:0], hx[3:0]};
	assign ev_oct = {st.escape_value[20:0], c[2:0]};

	always_comb begin
		st = st_q;
		if (word.start_req) begin
			st.phase          = tled_pkg::PH_BODY;
			st.digits_left    = 3'd0;
			st.escape_value   = 24'd0;
			st.unicode_escape = 1'b0;
			st.decoded_count  = 16'd0;
		end
	end

	always_comb begin
		st_d      = st;
		put       = 1'b0;
		put_val   = 8'd0;
		fail      = 1'b0;
		fail_code = tled_pkg::E_NONE;
		lit_end   = 1'b0;

		unique case (st.phase)
			tled_pkg::PH_BODY: begin
				if (c == tled_pkg::CH_DQ) begin
					lit_end = 1'b1;
				end else if (c == tled_pkg::CH_LF || c == tled_pkg::CH_CR
						|| c == tled_pkg::CH_FF) begin
					fail      = 1'b1;
					fail_code = tled_pkg::E_EOL;
				end else if (c == tled_pkg::CH_BSL) begin
					st_d.phase = tled_pkg::PH_ESC;
				end else if (c == tled_pkg::CH_NUL) begin
					fail      = 1'b1;
					fail_code = tled_pkg::E_NUL;
				end else begin
					put     = 1'b1;
					put_val = c;
				end
			end
			tled_pkg::PH_ESC: begin
				case (c) inside
					tled_pkg::CH_LN: begin
						put     = 1'b1;
						put_val = tled_pkg::CH_LF;
					end
					tled_pkg::CH_LT: begin
						put     = 1'b1;
						put_val = tled_pkg::CH_TAB;
					end
					tled_pkg::CH_LR: begin
						put     = 1'b1;
						put_val = tled_pkg::CH_CR;
					end
					tled_pkg::CH_LF_: begin
						put     = 1'b1;
						put_val = tled_pkg::CH_FF;
					end
					tled_pkg::CH_BSL, tled_pkg::CH_SQ, tled_pkg::CH_DQ: begin
						put     = 1'b1;
						put_val = c;
					end
					tled_pkg::CH_LX, tled_pkg::CH_UX, tled_pkg::CH_UU: begin
						st_d.phase          = tled_pkg::PH_HEX;
						st_d.unicode_escape = (c == tled_pkg::CH_UU);
						st_d.digits_left    = (c == tled_pkg::CH_UU) ?
							tled_pkg::UNI_DIGITS : tled_pkg::HEX_DIGITS;
						st_d.escape_value   = 24'd0;
					end
					[tled_pkg::CH_D0:tled_pkg::CH_D7]: begin
						st_d.phase        = tled_pkg::PH_OCT;
						st_d.escape_value = {21'd0, c[2:0]};
						st_d.digits_left  = tled_pkg::OCT_MORE;
					end
					default: begin
						fail      = 1'b1;
						fail_code = tled_pkg::E_UNKNOWN;
					end
				endcase
			end
			tled_pkg::PH_HEX: begin
				if (!hx[4]) begin
					fail      = 1'b1;
					fail_code = tled_pkg::E_BAD_HEX;
				end else begin
					st_d.escape_value = ev_hex;
					st_d.digits_left  = dl_dec;
					if (dl_dec == 3'd0) begin
						if (st.unicode_escape && ev_hex > 24'(tled_pkg::BYTE_MAX)) begin
							fail      = 1'b1;
							fail_code = tled_pkg::E_UNI_RNG;
						end else begin
							put     = 1'b1;
							put_val = ev_hex[7:0];
						end
					end
				end
			end
			tled_pkg::PH_OCT: begin
				if (c < tled_pkg::CH_D0 || c > tled_pkg::CH_D7) begin
					fail      = 1'b1;
					fail_code = tled_pkg::E_BAD_OCT;
				end else begin
					st_d.escape_value = ev_oct;
					st_d.digits_left  = dl_dec;
					if (dl_dec == 3'd0) begin
						if (ev_oct > 24'(tled_pkg::BYTE_MAX)) begin
							fail      = 1'b1;
							fail_code = tled_pkg::E_OCT_RNG;
						end else begin
							put     = 1'b1;
							put_val = ev_oct[7:0];
						end
					end
				end
			end
			default: begin
				st_d.phase = tled_pkg::PH_IDLE;
			end
		endcase

		res.has         = put | fail | lit_end;
		res.kind        = tled_pkg::K_BYTE;
		res.out_byte    = 8'd0;
		res.error_code  = tled_pkg::E_NONE;
		res.text_length = 16'd0;
		if (put) begin
			st_d.phase   = tled_pkg::PH_BODY;
			res.out_byte = put_val;
			if (st.decoded_count != tled_pkg::LEN_MAX) begin
				st_d.decoded_count = st.decoded_count + 16'd1;
			end
		end
		if (fail) begin
			st_d.phase     = tled_pkg::PH_IDLE;
			res.kind       = tled_pkg::K_ERR;
			res.error_code = fail_code;
		end
		if (lit_end) begin
			st_d.phase      = tled_pkg::PH_IDLE;
			res.kind        = tled_pkg::K_END;
			res.text_length = st.decoded_count;
		end
	end

endmodule

>>> rtl/core/tled_out_stage.sv
// result register: holds one result word until the receiver takes it
module tled_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              process,
	input  tled_pkg::result_t res,
	input  logic              stall,
	output logic              valid,
	output logic              blocked,
	output logic [1:0]        kind,
	output logic [7:0]        out_byte,
	output logic [2:0]        error_code,
	output logic [15:0]       text_length
);

	logic              valid_q;
	tled_pkg::result_t res_q;
	logic              open;

	assign blocked = valid_q & stall;
	assign open    = ~blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (open) begin
			valid_q <= process & res.has;
		end
	end

	always_ff @(posedge clk) begin
		if (open && process) begin
			res_q <= res;
		end
	end

	assign valid       = valid_q;
	assign kind        = res_q.kind;
	assign out_byte    = res_q.out_byte;
	assign error_code  = res_q.error_code;
	assign text_length = res_q.text_length;

endmodule

>>> rtl/core/text_literal_escape_decoder.sv
// top level of the text literal escape decoder
//
// input channel: item_valid / item_stall carry one raw body byte (ch) per word,
// with start_req set on the first byte after the opening quote
// result channel: result_valid / result_stall carry kind, out_byte,
// error_code and text_length; words that cause no result produce nothing
// throughput: one word per cycle while result_stall holds no result, set by the
// single decode step between the input register and the result register
// a result is decoded from the word in the input register and presented from the result register
// when result_stall holds a result, one more word is captured in the input
// register, then item_stall rises until the result is taken
// reset clears both register valids and returns the decoder to idle with a
// zero length count; bytes arriving in idle without start_req are dropped
`include "text_literal_escape_decoder_macros.svh"

module text_literal_escape_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  ch,
	input  logic        start_req,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [2:0]  error_code,
	output logic [15:0] text_length
);

	tled_pkg::word_t   word_s1;
	tled_pkg::state_t  st_q;
	tled_pkg::state_t  st_d;
	tled_pkg::result_t res;
	logic              process;
	logic              blocked;

	tled_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (item_valid),
		.ch       (ch),
		.start_req(start_req),
		.blocked  (blocked),
		.stall    (item_stall),
		.process  (process),
		.word_s1  (word_s1)
	);

	tled_step u_step (
		.word(word_s1),
		.st_q(st_q),
		.st_d(st_d),
		.res (res)
	);

	// decoder state advances only when the held word is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase          <= tled_pkg::PH_IDLE;
			st_q.digits_left    <= 3'd0;
			st_q.escape_value   <= 24'd0;
			st_q.unicode_escape <= 1'b0;
			st_q.decoded_count  <= 16'd0;
		end else if (process) begin
			st_q <= st_d;
		end
	end

	tled_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.process    (process),
		.res        (res),
		.stall      (result_stall),
		.valid      (result_valid),
		.blocked    (blocked),
		.kind       (kind),
		.out_byte   (out_byte),
		.error_code (error_code),
		.text_length(text_length)
	);

	`TLED_ASSERT_IMP(a_err_code, result_valid, ((kind == tled_pkg::K_ERR) == (error_code != tled_pkg::E_NONE)), "error code does not match result kind")
	`TLED_ASSERT_IMP(a_len_end, result_valid && kind != tled_pkg::K_END, text_length == 16'd0, "length reported outside an end result")
	`TLED_ASSERT_IMP(a_kind_ok, result_valid, kind != 2'd3, "undefined result kind")
	`TLED_ASSERT_NXT(a_hold_busy, item_stall, st_q == $past(st_q), "decoder state moved while input was stalled")

endmodule
